// ===== rtl/text_mode_cell_renderer_core_macros.svh =====
// assertion helpers used by the renderer rtl
`ifndef TEXT_MODE_CELL_RENDERER_CORE_MACROS_SVH
`define TEXT_MODE_CELL_RENDERER_CORE_MACROS_SVH

// same-cycle implication
`define TMCR_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TMCR_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tmcr_pkg.sv =====
package tmcr_pkg;

	localparam int TMCR_COLS   = 64;
	localparam int TMCR_ROWS   = 32;
	localparam int GLYPH_W     = 6;
	localparam int GLYPH_H     = 9;
	localparam int GLYPH_DEPTH = 256 * GLYPH_H;
	localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
	localparam int CURSOR_LINE = 7;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'hF0;

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_CLEAR   = 3'd1,
		OP_SCROLL  = 3'd2,
		OP_CURSOR  = 3'd3,
		OP_BLINK   = 3'd4,
		OP_PALETTE = 3'd5,
		OP_GLYPH   = 3'd6,
		OP_PIXEL   = 3'd7
	} op_t;

	// rgb565, byte swapped
	function automatic logic [15:0] pcol(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		logic [15:0] c;
		c = {r[7:3], g[7:2], b[7:3]};
		return {c[7:0], c[15:8]};
	endfunction

	localparam logic [15:0] START_PALETTE [16] = '{
		pcol(8'hf0, 8'hf0, 8'hf0), pcol(8'hf2, 8'hb2, 8'h33),
		pcol(8'he5, 8'h7f, 8'hd8), pcol(8'h99, 8'hb2, 8'hf2),
		pcol(8'hde, 8'hde, 8'h6c), pcol(8'h7f, 8'hcc, 8'h19),
		pcol(8'hf2, 8'hb2, 8'hcc), pcol(8'h4c, 8'h4c, 8'h4c),
		pcol(8'h99, 8'h99, 8'h99), pcol(8'h4c, 8'h99, 8'hb2),
		pcol(8'hb2, 8'h66, 8'he5), pcol(8'h33, 8'h66, 8'hcc),
		pcol(8'h7f, 8'h66, 8'h4c), pcol(8'h57, 8'ha6, 8'h4e),
		pcol(8'hcc, 8'h4c, 8'h4c), pcol(8'h11, 8'h11, 8'h11)
	};

endpackage

// ===== rtl/tmcr_req_if.sv =====
interface tmcr_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic signed [7:0]  col_pos;
	logic signed [6:0]  row_pos;
	logic [7:0]         char_code;
	logic [7:0]         attribute;
	logic signed [6:0]  scroll_lines;
	logic signed [4:0]  color_index;
	logic [15:0]        palette_value;
	logic [3:0]         glyph_row;
	logic [5:0]         glyph_bits;
	logic [8:0]         pixel_x;
	logic [8:0]         pixel_y;

	modport source (
		output valid, operation, col_pos, row_pos, char_code, attribute, scroll_lines,
		       color_index, palette_value, glyph_row, glyph_bits, pixel_x, pixel_y,
		input  ready
	);
	modport sink (
		input  valid, operation, col_pos, row_pos, char_code, attribute, scroll_lines,
		       color_index, palette_value, glyph_row, glyph_bits, pixel_x, pixel_y,
		output ready
	);
endinterface

// ===== rtl/tmcr_rsp_if.sv =====
interface tmcr_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_color;
	logic        ignored;

	modport source (output valid, pixel_color, ignored, input ready);
	modport sink (input valid, pixel_color, ignored, output ready);
endinterface

// ===== rtl/text_mode_cell_renderer_core.sv =====
// channel | dir | payload                                   | transaction when
// req     | in  | operation, positions, codes, pixel x/y    | valid & ready
// rsp     | out | pixel_color, ignored                      | valid & ready
//
// after reset a clearing pass over max(COLS*ROWS, 2304) addresses fills both memories;
// req.ready stays low meanwhile
// one item at a time: a pixel read steps through cell memory, then glyph memory,
// then palette; clear and scroll make one cell write per cycle, set by the single
// write port of the cell memory
// rsp is a register: req is taken again while a result waits, and the next
// result waits in the done state until rsp is taken
`include "text_mode_cell_renderer_core_macros.svh"

module text_mode_cell_renderer_core #(
	parameter int COLS = tmcr_pkg::TMCR_COLS,
	parameter int ROWS = tmcr_pkg::TMCR_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	tmcr_req_if.sink    req,
	tmcr_rsp_if.source  rsp
);
	import tmcr_pkg::*;

	localparam int CELLS   = COLS * ROWS;
	localparam int CA      = $clog2(CELLS);
	localparam int CC      = CA + 1;
	localparam int RST_LEN = (CELLS > GLYPH_DEPTH) ? CELLS : GLYPH_DEPTH;
	localparam int RW      = $clog2(RST_LEN);

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SWEEP = 7'b0000100,
		ST_PIXA  = 7'b0001000,
		ST_PIXB  = 7'b0010000,
		ST_PIXC  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [15:0]         cell_mem  [CELLS];
	logic [5:0]          glyph_mem [GLYPH_DEPTH];
	logic [15:0]         pal_q     [16];

	logic [RW-1:0]       rst_cnt_q;
	logic [CA-1:0]       sw_d_q;
	logic [CC-1:0]       sw_cnt_q;
	logic [CA-1:0]       sw_off_q;
	logic                sw_up_q;
	logic                sw_copy_q;
	logic [7:0]          sw_fill_q;
	logic                pend_s1;
	logic [CA-1:0]       pend_addr_s1;
	logic                pend_mem_s1;

	logic [7:0]          cur_col_q;
	logic [6:0]          cur_row_q;
	logic [4:0]          cur_clr_q;
	logic                cur_vis_q;

	logic [8:0]          px_q;
	logic [8:0]          py_q;
	logic [6:0]          cx_q;
	logic [5:0]          cy_q;
	logic [2:0]          xr_q;
	logic [3:0]          yr_q;
	logic [7:0]          attr_q;

	logic [15:0]         cell_rd_q;
	logic [5:0]          glyph_rd_q;
	logic [15:0]         res_pixel_q;
	logic                res_flag_q;
	logic                out_valid_q;
	logic [15:0]         out_pixel_q;
	logic                out_flag_q;

	// request decode
	op_t                 op;
	logic                accept;
	logic                wr_ok;
	logic [CA-1:0]       wr_addr;
	logic [CA-1:0]       row_base;
	logic [6:0]          mag;
	logic                big;
	logic [CA-1:0]       scr_off;
	logic                px_ok;
	logic                py_ok;
	logic [6:0]          cx_w;
	logic [5:0]          cy_w;

	assign op     = op_t'(req.operation);
	assign accept = req.valid && req.ready;
	assign wr_ok  = !req.col_pos[7] && ({1'b0, $unsigned(req.col_pos)} < 9'(COLS)) &&
	                !req.row_pos[6] && ({1'b0, $unsigned(req.row_pos)} < 8'(ROWS));
	assign wr_addr  = CA'(CC'(req.row_pos[5:0]) * CC'(COLS) + CC'(req.col_pos[6:0]));
	assign row_base = CA'(CC'(req.row_pos[5:0]) * CC'(COLS));
	assign mag      = req.scroll_lines[6] ? 7'(-req.scroll_lines) : 7'(req.scroll_lines);
	assign big      = {1'b0, mag} >= 8'(ROWS);
	assign scr_off  = CA'(CC'(mag) * CC'(COLS));
	assign px_ok    = {2'b00, req.pixel_x} < 11'(COLS * GLYPH_W);
	assign py_ok    = {2'b00, req.pixel_y} < 11'(ROWS * GLYPH_H);
	// divide by 6 and by 9 through reciprocals, exact for 9-bit inputs
	assign cx_w     = 7'((18'(req.pixel_x) * 18'd171) >> 10);
	assign cy_w     = 6'((16'(req.pixel_y) * 16'd57) >> 9);

	// sweep source
	logic [CC-1:0]       src_up;
	logic                src_ok;
	logic [CA-1:0]       src_addr;
	logic                sw_step;

	assign src_up  = {1'b0, sw_d_q} + {1'b0, sw_off_q};
	assign sw_step = (state_q == ST_SWEEP) && (sw_cnt_q != '0);
	always_comb begin
		if (sw_up_q) begin
			src_ok   = sw_copy_q && (src_up < CC'(CELLS));
			src_addr = src_up[CA-1:0];
		end else begin
			src_ok   = sw_copy_q && (sw_d_q >= sw_off_q);
			src_addr = sw_d_q - sw_off_q;
		end
	end

	// memory ports
	logic [CC-1:0]       pix_full;
	logic                cell_we;
	logic [CA-1:0]       cell_waddr;
	logic [15:0]         cell_wdata;
	logic                cell_re;
	logic [CA-1:0]       cell_raddr;
	logic                glyph_we;
	logic [GLYPH_AW-1:0] glyph_waddr;
	logic [5:0]          glyph_wdata;
	logic [GLYPH_AW-1:0] glyph_raddr;
	logic                in_init;

	assign pix_full = CC'(CC'(cy_q) * CC'(COLS) + CC'(cx_q));
	assign in_init  = (state_q == ST_INIT);

	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = '0;
		cell_wdata = '0;
		if (in_init) begin
			cell_we    = {1'b0, rst_cnt_q} < (RW + 1)'(CELLS);
			cell_waddr = CA'(rst_cnt_q);
			cell_wdata = {RESET_ATTR, BLANK_CHAR};
		end else if (pend_s1) begin
			cell_we    = 1'b1;
			cell_waddr = pend_addr_s1;
			cell_wdata = pend_mem_s1 ? cell_rd_q : {sw_fill_q, BLANK_CHAR};
		end else if (accept && op == OP_WRITE && wr_ok) begin
			cell_we    = 1'b1;
			cell_waddr = wr_addr;
			cell_wdata = {req.attribute, req.char_code};
		end
	end

	always_comb begin
		cell_re    = 1'b0;
		cell_raddr = '0;
		if (sw_step && src_ok) begin
			cell_re    = 1'b1;
			cell_raddr = src_addr;
		end else if (state_q == ST_PIXA) begin
			cell_re    = 1'b1;
			cell_raddr = pix_full[CA-1:0];
		end
	end

	always_comb begin
		glyph_we    = 1'b0;
		glyph_waddr = '0;
		glyph_wdata = '0;
		if (in_init) begin
			glyph_we    = {1'b0, rst_cnt_q} < (RW + 1)'(GLYPH_DEPTH);
			glyph_waddr = GLYPH_AW'(rst_cnt_q);
		end else if (accept && op == OP_GLYPH && req.glyph_row < 4'(GLYPH_H)) begin
			glyph_we    = 1'b1;
			glyph_waddr = GLYPH_AW'(GLYPH_AW'(req.char_code) * GLYPH_AW'(GLYPH_H) +
			                        GLYPH_AW'(req.glyph_row));
			glyph_wdata = req.glyph_bits;
		end
	end

	assign glyph_raddr = GLYPH_AW'(GLYPH_AW'(cell_rd_q[7:0]) * GLYPH_AW'(GLYPH_H) +
	                               GLYPH_AW'(yr_q));

	always_ff @(posedge clk) begin
		if (cell_we)
			cell_mem[cell_waddr] <= cell_wdata;
		if (cell_re)
			cell_rd_q <= cell_mem[cell_raddr];
	end

	always_ff @(posedge clk) begin
		if (glyph_we)
			glyph_mem[glyph_waddr] <= glyph_wdata;
		if (state_q == ST_PIXB)
			glyph_rd_q <= glyph_mem[glyph_raddr];
	end

	// pixel colour select
	logic       hit;
	logic       fg;
	logic [3:0] pal_idx;

	assign hit = cur_vis_q && !cur_col_q[7] && ({1'b0, cur_col_q} < 9'(COLS)) &&
	             (8'(cx_q) == cur_col_q) && !cur_row_q[6] && (7'(cy_q) == cur_row_q) &&
	             (yr_q == 4'(CURSOR_LINE));
	assign fg      = glyph_rd_q[xr_q];
	assign pal_idx = hit ? cur_clr_q[3:0] : (fg ? attr_q[3:0] : attr_q[7:4]);

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			rst_cnt_q   <= '0;
			sw_cnt_q    <= '0;
			sw_up_q     <= 1'b1;
			sw_copy_q   <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			cur_clr_q   <= '1;
			cur_vis_q   <= 1'b0;
			for (int i = 0; i < 16; i++)
				pal_q[i] <= START_PALETTE[i];
		end else begin
			pend_s1 <= sw_step;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_INIT: begin
					rst_cnt_q <= rst_cnt_q + 1'b1;
					if (rst_cnt_q == RW'(RST_LEN - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						case (op)
							OP_CLEAR: begin
								sw_up_q   <= 1'b1;
								sw_copy_q <= 1'b0;
								if (req.row_pos[6]) begin
									sw_cnt_q <= CC'(CELLS);
									state_q  <= ST_SWEEP;
								end else if ({1'b0, $unsigned(req.row_pos)} < 8'(ROWS)) begin
									sw_cnt_q <= CC'(COLS);
									state_q  <= ST_SWEEP;
								end
							end
							OP_SCROLL: begin
								if (big) begin
									sw_up_q   <= 1'b1;
									sw_copy_q <= 1'b0;
									sw_cnt_q  <= CC'(CELLS);
									state_q   <= ST_SWEEP;
								end else if (mag != '0) begin
									sw_up_q   <= !req.scroll_lines[6];
									sw_copy_q <= 1'b1;
									sw_cnt_q  <= CC'(CELLS);
									state_q   <= ST_SWEEP;
								end
							end
							OP_CURSOR: begin
								cur_col_q <= req.col_pos;
								cur_row_q <= req.row_pos;
								cur_clr_q <= req.color_index;
								if (req.color_index[4])
									cur_vis_q <= 1'b0;
							end
							OP_BLINK: begin
								if (!cur_clr_q[4])
									cur_vis_q <= !cur_vis_q;
							end
							OP_PALETTE: begin
								if (!req.color_index[4])
									pal_q[req.color_index[3:0]] <= req.palette_value;
							end
							OP_PIXEL: begin
								if (px_ok && py_ok)
									state_q <= ST_PIXA;
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					if (sw_cnt_q != '0)
						sw_cnt_q <= sw_cnt_q - 1'b1;
					else
						state_q <= ST_DONE;
				end
				ST_PIXA: state_q <= ST_PIXB;
				ST_PIXB: state_q <= ST_PIXC;
				ST_PIXC: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			res_pixel_q <= '0;
			res_flag_q  <= 1'b0;
			sw_fill_q   <= req.attribute;
			px_q        <= req.pixel_x;
			py_q        <= req.pixel_y;
			cx_q        <= cx_w;
			cy_q        <= cy_w;
			case (op)
				OP_WRITE:   res_flag_q <= !wr_ok;
				OP_CLEAR: begin
					res_flag_q <= !req.row_pos[6] &&
					              ({1'b0, $unsigned(req.row_pos)} >= 8'(ROWS));
					sw_d_q     <= req.row_pos[6] ? '0 : row_base;
				end
				OP_SCROLL: begin
					sw_off_q <= scr_off;
					sw_d_q   <= (!big && req.scroll_lines[6]) ? CA'(CELLS - 1) : '0;
				end
				OP_PALETTE: res_flag_q <= req.color_index[4];
				OP_GLYPH:   res_flag_q <= req.glyph_row >= 4'(GLYPH_H);
				OP_PIXEL:   res_flag_q <= !(px_ok && py_ok);
				default: ;
			endcase
		end
		if (sw_step) begin
			pend_addr_s1 <= sw_d_q;
			pend_mem_s1  <= src_ok;
			sw_d_q       <= sw_up_q ? sw_d_q + 1'b1 : sw_d_q - 1'b1;
		end
		if (state_q == ST_PIXA) begin
			xr_q <= 3'(px_q - 9'(10'(cx_q) * 10'd6));
			yr_q <= 4'(py_q - 9'(10'(cy_q) * 10'd9));
		end
		if (state_q == ST_PIXB)
			attr_q <= cell_rd_q[15:8];
		if (state_q == ST_PIXC)
			res_pixel_q <= pal_q[pal_idx];
		if (out_load) begin
			out_pixel_q <= res_pixel_q;
			out_flag_q  <= res_flag_q;
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.pixel_color = out_pixel_q;
	assign rsp.ignored     = out_flag_q;

	`TMCR_ASSERT_NOW(a_pend_no_accept_write, clk, arst_n, pend_s1, !accept,
		"sweep write overlaps an accepted transaction")
	`TMCR_ASSERT_NEXT(a_done_loads_rsp, clk, arst_n, out_load, rsp.valid,
		"finished result did not reach rsp")
	`TMCR_ASSERT_NOW(a_pixel_addr_range, clk, arst_n, state_q == ST_PIXA,
		pix_full < CC'(CELLS), "pixel read beyond cell memory")

endmodule
